// File: rtl/srx_pkg.sv
`default_nettype none

package srx_pkg;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_GET    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK               = 3'd0,
      STAT_START_MISALIGNED = 3'd1,
      STAT_SIZE_MISALIGNED  = 3'd2,
      STAT_ZERO_SIZE        = 3'd3,
      STAT_FULL             = 3'd4,
      STAT_BAD_INDEX        = 3'd5
   } status_type;

   localparam int             PAGE_LOG2_W     = 5;
   localparam logic [4:0]     PAGE_LOG2_RESET = 5'd12;
   // Register index as decoded from the word address.
   localparam logic           CSR_IDX_PAGE    = 1'b0;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] address;
      logic [63:0] range_size;
      logic [31:0] buffer_tag;
      logic [5:0]  entry_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        excluded;
      logic [63:0] entry_start;
      logic [63:0] entry_length;
      logic [31:0] entry_tag;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] range_start;
      logic [63:0] range_end;
      logic [31:0] range_tag;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE      = 4'd0,
      S_CLEAR     = 4'd1,
      S_ADD_CHECK = 4'd2,
      S_ADD_SCAN  = 4'd3,
      S_ADD_PLACE = 4'd4,
      S_LOOKUP    = 4'd5,
      S_LK_STEP   = 4'd6,
      S_GET       = 4'd7,
      S_DONE      = 4'd8
   } state_type;

   typedef struct packed {
      logic load_item;
      logic check;
      logic clear_count;
      logic scan_start;
      logic scan_shift;
      logic place_new;
      logic lk_start;
      logic lk_step;
      logic get_read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      kind_type new_kind;
      logic     check_ok;
      logic     count_zero;
      logic     scan_greater;
      logic     scan_last;
      logic     lk_more;
      logic     out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/srx_ram.sv
`default_nettype none

module srx_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/srx_ctrl.sv
`default_nettype none

module srx_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire srx_pkg::sts_type sts,
   output      srx_pkg::cmd_type cmd
);

   import srx_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               case (sts.new_kind)
                  KIND_CLEAR:  state_in = S_CLEAR;
                  KIND_ADD:    state_in = S_ADD_CHECK;
                  KIND_LOOKUP: state_in = S_LOOKUP;
                  KIND_GET:    state_in = S_GET;
                  default:     state_in = S_CLEAR;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.check       = 1'b1;
            cmd.clear_count = 1'b1;
            state_in        = S_DONE;
         end
         S_ADD_CHECK: begin
            cmd.check = 1'b1;
            if (!sts.check_ok) begin
               state_in = S_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = sts.count_zero ? S_ADD_PLACE : S_ADD_SCAN;
            end
         end
         S_ADD_SCAN: begin
            // Entries with a larger start move up one slot until the gap is found.
            if (sts.scan_greater) begin
               cmd.scan_shift = 1'b1;
               state_in       = sts.scan_last ? S_ADD_PLACE : S_ADD_SCAN;
            end else begin
               cmd.place_new = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_ADD_PLACE: begin
            cmd.place_new = 1'b1;
            state_in      = S_DONE;
         end
         S_LOOKUP: begin
            cmd.check    = 1'b1;
            cmd.lk_start = 1'b1;
            state_in     = sts.count_zero ? S_DONE : S_LK_STEP;
         end
         S_LK_STEP: begin
            cmd.lk_step = 1'b1;
            if (!sts.lk_more) begin
               state_in = S_DONE;
            end
         end
         S_GET: begin
            cmd.check    = 1'b1;
            cmd.get_read = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/srx_datapath.sv
`default_nettype none

module srx_datapath #(
   parameter int MAX_RANGES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [4:0]       page_log2,
   input  wire srx_pkg::req_type req_data,
   input  wire srx_pkg::cmd_type cmd,
   output      srx_pkg::sts_type sts,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      srx_pkg::rsp_type rsp_data
);

   import srx_pkg::*;

   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int EW = $bits(entry_type);

   req_type          item_ff, item_in;
   status_type       status_ff, status_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic [CW-1:0]    mid_ff, mid_in;
   logic             found_ff, found_in;
   logic [63:0]      cand_end_ff, cand_end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [63:0]      mask;
   status_type       check_status;
   entry_type        rd_entry;
   entry_type        new_entry;
   logic             lk_less;
   logic [CW-1:0]    lo_step;
   logic [CW-1:0]    hi_step;
   logic [CW:0]      mid_sum;
   logic [CW-1:0]    mid_step;
   logic             out_free;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [EW-1:0]    ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [EW-1:0]    ram_rd_data;

   srx_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_RANGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Status toward the controller depends on registers and inputs only, never on commands.
   always_comb begin
      mask     = ~({64{1'b1}} << page_log2);
      rd_entry = entry_type'(ram_rd_data);

      check_status = STAT_OK;
      case (item_ff.kind)
         KIND_ADD: begin
            if ((item_ff.address & mask) != 64'd0) begin
               check_status = STAT_START_MISALIGNED;
            end else if ((item_ff.range_size & mask) != 64'd0) begin
               check_status = STAT_SIZE_MISALIGNED;
            end else if (item_ff.range_size == 64'd0) begin
               check_status = STAT_ZERO_SIZE;
            end else if (count_ff >= CW'(MAX_RANGES)) begin
               check_status = STAT_FULL;
            end
         end
         KIND_GET: begin
            if (32'(item_ff.entry_index) >= 32'(count_ff)) begin
               check_status = STAT_BAD_INDEX;
            end
         end
         default: begin
            check_status = STAT_OK;
         end
      endcase

      new_entry.range_start = item_ff.address;
      new_entry.range_end   = item_ff.address + item_ff.range_size;
      new_entry.range_tag   = item_ff.buffer_tag;

      // One halving step: the last entry at or below the address is the candidate.
      lk_less  = item_ff.address < rd_entry.range_start;
      lo_step  = lk_less ? lo_ff : mid_ff + CW'(1);
      hi_step  = lk_less ? mid_ff : hi_ff;
      mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
      mid_step = mid_sum[CW:1];

      out_free = !rsp_valid_ff || rsp_ready;

      sts.new_kind     = req_data.kind;
      sts.check_ok     = check_status == STAT_OK;
      sts.count_zero   = count_ff == '0;
      sts.scan_greater = rd_entry.range_start > item_ff.address;
      sts.scan_last    = cursor_ff == CW'(1);
      sts.lk_more      = lo_step < hi_step;
      sts.out_free     = out_free;
   end

   always_comb begin
      ram_rd_en = cmd.scan_start || cmd.scan_shift || cmd.lk_start || cmd.lk_step
                  || cmd.get_read;
      if (cmd.scan_start) begin
         ram_rd_addr = AW'(count_ff - CW'(1));
      end else if (cmd.scan_shift) begin
         ram_rd_addr = AW'(cursor_ff - CW'(2));
      end else if (cmd.lk_start) begin
         ram_rd_addr = AW'(count_ff >> 1);
      end else if (cmd.lk_step) begin
         ram_rd_addr = AW'(mid_step);
      end else begin
         ram_rd_addr = AW'(item_ff.entry_index);
      end

      ram_wr_en   = cmd.scan_shift || cmd.place_new;
      ram_wr_addr = AW'(cursor_ff);
      ram_wr_data = cmd.scan_shift ? ram_rd_data : EW'(new_entry);

      item_in      = cmd.load_item ? req_data : item_ff;
      status_in    = cmd.check ? check_status : status_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      found_in     = found_ff;
      cand_end_in  = cand_end_ff;

      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.scan_start) begin
         cursor_in = count_ff;
      end
      if (cmd.scan_shift) begin
         cursor_in = cursor_ff - CW'(1);
      end
      if (cmd.place_new) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.lk_start) begin
         lo_in    = '0;
         hi_in    = count_ff;
         mid_in   = count_ff >> 1;
         found_in = 1'b0;
      end
      if (cmd.lk_step) begin
         lo_in  = lo_step;
         hi_in  = hi_step;
         mid_in = mid_step;
         if (!lk_less) begin
            found_in    = 1'b1;
            cand_end_in = rd_entry.range_end;
         end
      end

      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = status_ff;
         rsp_in.excluded     = (item_ff.kind == KIND_LOOKUP) && found_ff
                               && (item_ff.address < cand_end_ff);
         rsp_in.entry_start  = 64'd0;
         rsp_in.entry_length = 64'd0;
         rsp_in.entry_tag    = 32'd0;
         if ((item_ff.kind == KIND_GET) && (status_ff == STAT_OK)) begin
            rsp_in.entry_start  = rd_entry.range_start;
            rsp_in.entry_length = rd_entry.range_end - rd_entry.range_start;
            rsp_in.entry_tag    = rd_entry.range_tag;
         end
         rsp_in.entry_count  = 7'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      status_ff   <= status_in;
      cursor_ff   <= cursor_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      found_ff    <= found_in;
      cand_end_ff <= cand_end_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/sorted_range_exclusion_table.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    srx_pkg::req_type (kind, address, size, tag, index)
// rsp       out        rsp_valid/ready    srx_pkg::rsp_type (status, excluded, entry, count)
// csr       in         APB psel/penable   page_size_log2 at byte address 0
//
// Clear, get and rejected adds pass through their own state into the last state, where the
// result word is registered and turns valid. A lookup repeats a halving step until the range
// closes, and an add moves each entry with a larger start up one slot, then places the new one.
// Reset clears the entry count and the result valid and sets page_size_log2 to 12; the
// entry memory needs no clearing pass. While rsp_ready is low the result register holds
// its word, one more request word is taken in, and its result then waits in the last state.

module sorted_range_exclusion_table #(
   parameter int MAX_RANGES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire srx_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      srx_pkg::rsp_type rsp_data,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output      logic [31:0]      csr_prdata,
   output      logic             csr_pready
);

   import srx_pkg::*;

   logic [PAGE_LOG2_W-1:0] page_log2_ff;
   logic [PAGE_LOG2_W-1:0] page_log2_in;
   logic                   csr_write;
   cmd_type                cmd;
   sts_type                sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      page_log2_in = page_log2_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_PAGE)) begin
         page_log2_in = csr_pwdata[PAGE_LOG2_W-1:0];
      end
      csr_prdata = (csr_paddr[2] == CSR_IDX_PAGE) ? 32'(page_log2_ff) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_log2_ff <= PAGE_LOG2_RESET;
      end else begin
         page_log2_ff <= page_log2_in;
      end
   end

   srx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srx_datapath #(
      .MAX_RANGES (MAX_RANGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .page_log2 (page_log2_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // The memory sees at most one kind of access command per cycle.
   a_one_mem_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.scan_start, cmd.scan_shift, cmd.place_new, cmd.lk_start,
                cmd.lk_step, cmd.get_read}))
      else $error("more than one memory command at once");

   // A result is only loaded when the output register is free.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("result loaded over a pending word");

   // Only one word is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

   // Failed adds and gets never report a hit or entry data.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STAT_OK)) |->
         (!rsp_data.excluded && (rsp_data.entry_start == 64'd0)
          && (rsp_data.entry_tag == 32'd0)))
      else $error("failed word carries data");
`endif

endmodule

`default_nettype wire
